// ===== rtl/core/ocv_pkg.sv =====
// ----------------------------------------------------------------------------
// ocv_pkg
// Shared types, curve tables and widths for the OCV state-of-charge lookup.
// ----------------------------------------------------------------------------
package ocv_pkg;

    localparam int NUM_POINTS  = 15;
    localparam int NUM_SEGS    = NUM_POINTS - 1;
    localparam int MV_W        = 16;
    localparam int PCT_W       = 7;
    localparam int SEG_W       = (NUM_SEGS > 1) ? $clog2(NUM_SEGS) : 1;
    localparam int PROD_W      = MV_W + PCT_W;
    localparam int RECIP_SHIFT = PROD_W;
    localparam int RECIP_W     = PROD_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Curve breakpoints, rising voltage.
    localparam logic [MV_W-1:0] CURVE_MV [NUM_POINTS] = '{
        16'd3000, 16'd3200, 16'd3400, 16'd3600, 16'd3700,
        16'd3750, 16'd3800, 16'd3850, 16'd3900, 16'd3950,
        16'd4000, 16'd4050, 16'd4100, 16'd4150, 16'd4200
    };

    localparam logic [PCT_W-1:0] CURVE_PCT [NUM_POINTS] = '{
        7'd0,  7'd3,  7'd5,  7'd10, 7'd20,
        7'd30, 7'd40, 7'd50, 7'd60, 7'd70,
        7'd80, 7'd85, 7'd90, 7'd95, 7'd100
    };

    // Segment span in mV (end minus start).
    localparam logic [MV_W-1:0] SEG_SPAN [NUM_SEGS] = '{
        16'd200, 16'd200, 16'd200, 16'd100, 16'd50, 16'd50, 16'd50,
        16'd50,  16'd50,  16'd50,  16'd50,  16'd50, 16'd50, 16'd50
    };

    // floor(2^RECIP_SHIFT / span) per segment; zero for an empty span.
    localparam logic [RECIP_W-1:0] SEG_RECIP [NUM_SEGS] = '{
        24'd41943,  24'd41943,  24'd41943,  24'd83886,  24'd167772,
        24'd167772, 24'd167772, 24'd167772, 24'd167772, 24'd167772,
        24'd167772, 24'd167772, 24'd167772, 24'd167772
    };

    // One classified lookup travelling from front to back.
    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic [PCT_W-1:0] base;
        logic [PCT_W-1:0] rise;
        logic [MV_W-1:0]  offset;
    } job_t;

endpackage

// ===== rtl/core/ocv_front.sv =====
// ----------------------------------------------------------------------------
// ocv_front
// Accept a voltage, clamp it or pick its curve segment, and register the job.
// ----------------------------------------------------------------------------
module ocv_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ocv_pkg::MV_W-1:0]  batt_mv,
    output logic                      job_valid,
    input  logic                      job_ready,
    output ocv_pkg::job_t             job
);

    logic          valid_reg;
    logic          valid_next;
    ocv_pkg::job_t job_reg;
    ocv_pkg::job_t job_next;

    always_comb
    begin
        logic found;
        found    = 1'b0;
        job_next = '0;
        if (batt_mv <= ocv_pkg::CURVE_MV[0])
        begin
            job_next.base = ocv_pkg::CURVE_PCT[0];
        end
        else if (batt_mv >= ocv_pkg::CURVE_MV[ocv_pkg::NUM_POINTS-1])
        begin
            job_next.base = ocv_pkg::CURVE_PCT[ocv_pkg::NUM_POINTS-1];
        end
        else
        begin
            // first segment that brackets the voltage wins
            for (int k = 0; k < ocv_pkg::NUM_SEGS; k++)
            begin
                if (!found && batt_mv >= ocv_pkg::CURVE_MV[k]
                           && batt_mv <= ocv_pkg::CURVE_MV[k+1])
                begin
                    found         = 1'b1;
                    job_next.seg  = ocv_pkg::SEG_W'(k);
                    job_next.base = ocv_pkg::CURVE_PCT[k];
                    job_next.rise = (ocv_pkg::CURVE_PCT[k+1] > ocv_pkg::CURVE_PCT[k])
                                  ? ocv_pkg::CURVE_PCT[k+1] - ocv_pkg::CURVE_PCT[k]
                                  : '0;
                    job_next.offset = batt_mv - ocv_pkg::CURVE_MV[k];
                end
            end
        end
    end

    assign in_ready   = !valid_reg || job_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            job_reg <= job_next;
        end
    end

    assign job_valid = valid_reg;
    assign job       = job_reg;

endmodule

// ===== rtl/core/ocv_queue.sv =====
// ----------------------------------------------------------------------------
// ocv_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module ocv_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  ocv_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_ready,
    output ocv_pkg::job_t pop_job
);

    ocv_pkg::job_t                entry_reg [ocv_pkg::QUEUE_DEPTH];
    logic [ocv_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [ocv_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [ocv_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [ocv_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [ocv_pkg::QCNT_W-1:0]   count_reg;
    logic [ocv_pkg::QCNT_W-1:0]   count_next;
    logic                         do_push;
    logic                         do_pop;

    assign push_ready = (count_reg != ocv_pkg::QCNT_W'(ocv_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + ocv_pkg::QCNT_W'(do_push) - ocv_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/core/ocv_back.sv =====
// ----------------------------------------------------------------------------
// ocv_back
// Three-stage interpolation: rise*offset, reciprocal divide, correct and add.
// ----------------------------------------------------------------------------
module ocv_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      job_valid,
    output logic                      job_ready,
    input  ocv_pkg::job_t             job,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ocv_pkg::PCT_W-1:0] soc_percent
);

    localparam int FULL_W = ocv_pkg::PROD_W + ocv_pkg::RECIP_W;

    logic                            v1_reg, v1_next;
    logic                            v2_reg, v2_next;
    logic                            v3_reg, v3_next;
    logic                            rdy1, rdy2, rdy3;

    logic [ocv_pkg::SEG_W-1:0]       seg1_reg, seg2_reg;
    logic [ocv_pkg::PCT_W-1:0]       base1_reg, base2_reg;
    logic [ocv_pkg::PROD_W-1:0]      prod1_reg, prod2_reg;
    logic [ocv_pkg::PCT_W-1:0]       q0_reg;
    logic [ocv_pkg::PCT_W-1:0]       soc_reg;

    logic [ocv_pkg::PROD_W-1:0]      prod1_next;
    logic [FULL_W-1:0]               scaled;
    logic [ocv_pkg::PCT_W-1:0]       q0_next;
    logic [ocv_pkg::MV_W-1:0]        span2;
    logic [ocv_pkg::PROD_W-1:0]      qspan;
    logic [ocv_pkg::PROD_W-1:0]      remain;
    logic                            adjust;
    logic [ocv_pkg::PCT_W:0]         sum;

    // stall chain: a stage loads when the one after it has room
    assign rdy3      = !v3_reg || out_ready;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign job_ready = rdy1;

    assign v1_next = rdy1 ? job_valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg    : v2_reg;
    assign v3_next = rdy3 ? v2_reg    : v3_reg;

    // stage 1 math
    assign prod1_next = ocv_pkg::PROD_W'(job.rise) * ocv_pkg::PROD_W'(job.offset);

    // stage 2 math: quotient estimate, low by at most one
    assign scaled  = FULL_W'(prod1_reg) * FULL_W'(ocv_pkg::SEG_RECIP[seg1_reg]);
    assign q0_next = scaled[ocv_pkg::RECIP_SHIFT +: ocv_pkg::PCT_W];

    // stage 3 math: fix the estimate, add the segment base
    assign span2  = ocv_pkg::SEG_SPAN[seg2_reg];
    assign qspan  = ocv_pkg::PROD_W'(q0_reg) * ocv_pkg::PROD_W'(span2);
    assign remain = prod2_reg - qspan;
    assign adjust = (span2 != '0) && (remain >= ocv_pkg::PROD_W'(span2));
    assign sum    = (ocv_pkg::PCT_W+1)'(base2_reg) + (ocv_pkg::PCT_W+1)'(q0_reg)
                  + (ocv_pkg::PCT_W+1)'(adjust);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            seg1_reg  <= job.seg;
            base1_reg <= job.base;
            prod1_reg <= prod1_next;
        end
        if (rdy2)
        begin
            seg2_reg  <= seg1_reg;
            base2_reg <= base1_reg;
            prod2_reg <= prod1_reg;
            q0_reg    <= q0_next;
        end
        if (rdy3)
        begin
            soc_reg <= sum[ocv_pkg::PCT_W-1:0];
        end
    end

    assign out_valid   = v3_reg;
    assign soc_percent = soc_reg;

`ifndef SYNTHESIS
    // reciprocal estimate never falls short by more than one span
    assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && span2 != '0 |-> remain < (ocv_pkg::PROD_W'(span2) << 1))
        else $error("ocv_back: quotient estimate off by more than one");

    // a clamped or flat job has no product and no quotient
    assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && prod2_reg == '0 |-> q0_reg == '0 && !adjust)
        else $error("ocv_back: nonzero quotient from zero product");

    // a result never exceeds the top of the curve
    assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> soc_reg <= ocv_pkg::CURVE_PCT[ocv_pkg::NUM_POINTS-1])
        else $error("ocv_back: result above full charge");
`endif

endmodule

// ===== rtl/core/ocv_soc_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// ocv_soc_interpolator_top
// Battery voltage to state-of-charge lookup over a fixed OCV curve.
// ----------------------------------------------------------------------------
// Each slave transfer carries one battery voltage in millivolts; each master
// transfer returns one state of charge in whole percent, in the same order.
// The curve has 15 breakpoints from 3000 mV (0 %) to 4200 mV (100 %);
// voltages at or below the first point clamp to 0 %, at or above the last to
// 100 %, and in between the charge is linearly interpolated with floor
// division in the first segment that ends at or above the voltage. The block
// takes one transfer per clock and sustains that rate indefinitely while the
// master side keeps tready high. Master tvalid rises once a slave transfer
// that meets an idle queue has passed the front register that picks the
// segment, the two-entry queue and three back stages (rise times offset,
// multiply by the segment's stored reciprocal, then a one-step correction
// and the add of the segment base). The queue lets the front keep taking
// transfers after the master side stalls, until the queue is full.
module ocv_soc_interpolator_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [15:0] batt_mv
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata      // [6:0] soc_percent, [7] zero
);

    logic                      f_valid;
    logic                      f_ready;
    ocv_pkg::job_t             f_job;
    logic                      q_valid;
    logic                      q_ready;
    ocv_pkg::job_t             q_job;
    logic [ocv_pkg::PCT_W-1:0] soc_percent;

    // classify the voltage and hold the job for the queue
    ocv_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .batt_mv    (s_tdata[ocv_pkg::MV_W-1:0]),
        .job_valid  (f_valid),
        .job_ready  (f_ready),
        .job        (f_job)
    );

    // decouple front and back so either can stall alone
    ocv_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_job   (f_job),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_job    (q_job)
    );

    // interpolate and drive the output register
    ocv_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (q_valid),
        .job_ready   (q_ready),
        .job         (q_job),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .soc_percent (soc_percent)
    );

    // pad the result to a whole byte
    assign m_tdata = {1'b0, soc_percent};

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream test of the OCV state-of-charge lookup against a local curve model.
// ----------------------------------------------------------------------------
// A driver and a receiver idle and stall at random on both stream sides. A
// monitor predicts the charge for every voltage it sees accepted and checks
// each returned result in order. The stimulus starts with a directed sweep of
// the curve's edges, then runs random voltages, mostly inside the curve.
// ----------------------------------------------------------------------------
module testbench;

    import ocv_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int MAX_CYCLES   = 400000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int LONG_HOLD    = 150;
    localparam int SETTLE       = 16;

    // One pending stimulus entry: a voltage with the sender's gap after it,
    // or a marker that makes the sender wait until every result is back.
    typedef struct {
        logic [MV_W-1:0] mv;
        int unsigned     gap;
        bit              drain;
    } mv_item_t;

    typedef struct {
        logic [MV_W-1:0]  mv;
        logic [PCT_W-1:0] soc;
    } soc_expect_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // [15:0] batt_mv
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // [6:0] soc_percent, [7] zero

    mv_item_t    mv_pending [$];
    soc_expect_t soc_expected [$];

    int unsigned total_items    = 0;
    int unsigned sent_count     = 0;
    int unsigned recv_count     = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    int unsigned gap_left    = 0;
    bit          drain_hold  = 1'b0;
    int unsigned ready_wait  = 0;
    int unsigned long_hold   = 0;

    ocv_soc_interpolator_top i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Expected charge for one voltage: clamp outside the curve, otherwise
    // floor-interpolate in the first segment that ends at or above it.
    function automatic logic [PCT_W-1:0] soc_from_mv(input logic [MV_W-1:0] mv);
        int unsigned v;
        int unsigned lo_mv;
        int unsigned hi_mv;
        int unsigned lo_pct;
        int unsigned hi_pct;
        int unsigned rise;
        v = mv;
        if (v <= CURVE_MV[0])
            return CURVE_PCT[0];
        if (v >= CURVE_MV[NUM_POINTS-1])
            return CURVE_PCT[NUM_POINTS-1];
        for (int k = 0; k < NUM_POINTS - 1; k++)
        begin
            lo_mv = CURVE_MV[k];
            hi_mv = CURVE_MV[k+1];
            if (v >= lo_mv && v <= hi_mv)
            begin
                lo_pct = CURVE_PCT[k];
                hi_pct = CURVE_PCT[k+1];
                // a falling segment is flat
                rise = (hi_pct > lo_pct) ? hi_pct - lo_pct : 0;
                if (hi_mv == lo_mv)
                    return PCT_W'(lo_pct);
                return PCT_W'(lo_pct + (rise * (v - lo_mv)) / (hi_mv - lo_mv));
            end
        end
        return '0;
    endfunction

    // Mostly voltages inside the curve, some on or one off a breakpoint, and a
    // share of full-range values so that every input bit toggles.
    function automatic logic [MV_W-1:0] random_mv();
        int unsigned pick;
        int unsigned idx;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return MV_W'($urandom_range(2990, 4210));
        if (pick < 82)
        begin
            idx = $urandom_range(0, NUM_POINTS - 1);
            return MV_W'(CURVE_MV[idx] + $urandom_range(0, 2) - 1);
        end
        return MV_W'($urandom_range(0, 65535));
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic queue_mv(input logic [MV_W-1:0] mv, input int unsigned gap);
        mv_item_t item;
        item.mv    = mv;
        item.gap   = gap;
        item.drain = 1'b0;
        mv_pending.push_back(item);
        total_items++;
    endtask

    task automatic queue_drain();
        mv_item_t item;
        item.mv    = '0;
        item.gap   = 0;
        item.drain = 1'b1;
        mv_pending.push_back(item);
    endtask

    // Sender: hold the offered voltage until it transfers, then wait out the
    // item's gap before popping the next entry. A drain marker parks the
    // sender until all results are back.
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        mv_item_t nxt_item;
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            gap_left   <= 0;
            drain_hold <= 1'b0;
        end
        else if (s_tvalid && !s_tready)
        begin
            // hold the current offer
        end
        else if (gap_left != 0)
        begin
            s_tvalid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (drain_hold)
        begin
            s_tvalid <= 1'b0;
            if (recv_count == sent_count)
                drain_hold <= 1'b0;
        end
        else if (mv_pending.size() != 0)
        begin
            nxt_item = mv_pending.pop_front();
            if (nxt_item.drain)
            begin
                s_tvalid   <= 1'b0;
                drain_hold <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= nxt_item.mv;
                gap_left <= nxt_item.gap;
            end
        end
        else
        begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver: after each result draw a random wait with tready low, except in
    // alternate stretches of 64 results where tready stays up. Twice, drop
    // tready for a long stretch so the block backs up into its input.
    always @(posedge clk or negedge rst_n)
    begin : receive_proc
        int unsigned wait_draw;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            ready_wait <= 0;
            long_hold  <= 0;
        end
        else if (long_hold != 0)
        begin
            m_tready  <= 1'b0;
            long_hold <= long_hold - 1;
        end
        else if (m_tready && m_tvalid)
        begin
            wait_draw = recv_count[6] ? 0 : $urandom_range(0, 8);
            if (recv_count == 399 || recv_count == 899)
            begin
                m_tready  <= 1'b0;
                long_hold <= LONG_HOLD;
            end
            else if (wait_draw != 0)
            begin
                m_tready   <= 1'b0;
                ready_wait <= wait_draw - 1;
            end
        end
        else if (!m_tready)
        begin
            if (ready_wait != 0)
                ready_wait <= ready_wait - 1;
            else
                m_tready <= 1'b1;
        end
    end

    // Monitor: check the result side first, then predict for any voltage
    // accepted at this edge. A result can never leave on its input's edge.
    always @(posedge clk)
    begin : score_proc
        soc_expect_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                recv_count <= recv_count + 1;
                if (soc_expected.size() == 0)
                    report_mismatch($sformatf("unexpected result tdata=0x%02h", m_tdata));
                else
                begin
                    want = soc_expected.pop_front();
                    if (m_tdata[PCT_W-1:0] !== want.soc)
                        report_mismatch($sformatf("%0d mV: soc_percent %0d, want %0d",
                                                  want.mv, m_tdata[PCT_W-1:0], want.soc));
                    if (m_tdata[7] !== 1'b0)
                        report_mismatch($sformatf("%0d mV: pad bit set", want.mv));
                end
            end
            if (s_tvalid && s_tready)
            begin
                want.mv  = s_tdata;
                want.soc = soc_from_mv(s_tdata);
                soc_expected.push_back(want);
                sent_count <= sent_count + 1;
            end
        end
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == MAX_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus_proc
        logic [MV_W-1:0] edge_mv [$];
        bit              gapless;

        // Directed sweep: range ends, clamp boundaries, every inner
        // breakpoint (segment that ends there), and a few points between.
        edge_mv = '{16'd0, 16'd2999, 16'd3000, 16'd3001, 16'd3100, 16'd3200,
                    16'd3201, 16'd3399, 16'd3400, 16'd3600, 16'd3700, 16'd3725,
                    16'd3750, 16'd3800, 16'd3850, 16'd3900, 16'd3950, 16'd4000,
                    16'd4050, 16'd4100, 16'd4150, 16'd4199, 16'd4200, 16'd4201,
                    16'd65535};
        foreach (edge_mv[i])
            queue_mv(edge_mv[i], $urandom_range(0, 8));
        queue_drain();

        // Random part in blocks of 100: some blocks back to back, others
        // with random gaps. Pause once midway until every result is back.
        gapless = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
                gapless = ($urandom_range(0, 2) == 0) || (n == 300) || (n == 800);
            if (n == 600)
                queue_drain();
            queue_mv(random_mv(), gapless ? 0 : $urandom_range(0, 8));
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (mv_pending.size() != 0 || sent_count != total_items ||
               recv_count != sent_count)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (soc_expected.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", soc_expected.size()));

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ocv_pkg.sv
rtl/core/ocv_front.sv
rtl/core/ocv_queue.sv
rtl/core/ocv_back.sv
rtl/core/ocv_soc_interpolator_top.sv
dv/testbench.sv
